[rtl/handle_slot_table_macros.svh]
// ----------------------------------------------------------------------------
// handle slot table assertion macros
// shared property forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef HANDLE_SLOT_TABLE_MACROS_SVH
`define HANDLE_SLOT_TABLE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define HST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("handle slot table check failed");

// next-cycle implication, disabled while reset is asserted
`define HST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("handle slot table check failed");

`endif

[rtl/hst_pkg.sv]
// ----------------------------------------------------------------------------
// hst_pkg
// operation codes, status codes and shared types of the handle slot table
// ----------------------------------------------------------------------------
package hst_pkg;

    localparam int FUNC_W  = 3;
    localparam int STAT_W  = 3;
    localparam int WORD_W  = 32;
    localparam int LOCK_W  = 16;
    localparam int HOUT_W  = 31;
    localparam int TDATA_W = 72;

    localparam logic [WORD_W-1:0] HANDLE_TAG = 32'h8000_0000;
    localparam logic [LOCK_W-1:0] LOCK_MAX   = 16'hFFFF;

    localparam logic [FUNC_W-1:0] FN_ALLOC    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_FREE     = 3'd1;
    localparam logic [FUNC_W-1:0] FN_GET      = 3'd2;
    localparam logic [FUNC_W-1:0] FN_SET      = 3'd3;
    localparam logic [FUNC_W-1:0] FN_LOCK     = 3'd4;
    localparam logic [FUNC_W-1:0] FN_UNLOCK   = 3'd5;
    localparam logic [FUNC_W-1:0] FN_ISLOCKED = 3'd6;
    localparam logic [FUNC_W-1:0] FN_NONE     = 3'd7;

    localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_HANDLE = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FULL       = 3'd2;
    localparam logic [STAT_W-1:0] STAT_LOCKED     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NOT_LOCKED = 3'd4;
    localparam logic [STAT_W-1:0] STAT_ZERO_SIZE  = 3'd5;
    localparam logic [STAT_W-1:0] STAT_LOCK_OVF   = 3'd6;
    localparam logic [STAT_W-1:0] STAT_UNUSED     = 3'd7;

    // one slot entry as held in the table memory
    typedef struct packed {
        logic              in_use;
        logic [LOCK_W-1:0] lock;
        logic [WORD_W-1:0] word;   // logical size, or next free slot
    } t_entry;

    // bookkeeping actions of one operation
    typedef struct packed {
        logic wr;     // write entry back
        logic pop;    // take head of free list
        logic grow;   // take a never-used slot
        logic push;   // put slot on free list
    } t_act;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [WORD_W-1:0] size_out;
        logic              is_locked;
    } t_res;

endpackage

[rtl/hst_mem.sv]
// ----------------------------------------------------------------------------
// hst_mem
// slot entry memory, one write and one registered read port
// ----------------------------------------------------------------------------
module hst_mem
    import hst_pkg::*;
#(
    parameter int SLOTS = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data
);

    t_entry r_mem [0:SLOTS-1];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/hst_exec.sv]
// ----------------------------------------------------------------------------
// hst_exec
// modify step of one operation on the entry read from the slot memory
// ----------------------------------------------------------------------------
module hst_exec
    import hst_pkg::*;
(
    input  logic [FUNC_W-1:0] i_func,
    input  logic [WORD_W-1:0] i_size,
    input  logic              i_hok,        // handle decodes to a slot in range
    input  logic              i_full,       // alloc finds no slot
    input  logic              i_from_list,  // alloc takes the free list head
    input  logic [WORD_W-1:0] i_link,       // current free list head
    input  t_entry            i_entry,
    output t_entry            o_entry,
    output t_act              o_act,
    output t_res              o_res
);

    always_comb begin
        o_res   = '0;
        o_act   = '0;
        o_entry = i_entry;
        unique case (i_func)
            FN_ALLOC: begin
                if (i_full) begin
                    o_res.status = STAT_FULL;
                end else begin
                    o_act.wr        = 1'b1;
                    o_act.pop       = i_from_list;
                    o_act.grow      = !i_from_list;
                    o_entry.in_use  = 1'b1;
                    o_entry.lock    = '0;
                    o_entry.word    = i_size;
                end
            end
            FN_NONE: begin
                o_res.status = STAT_OK;
            end
            default: begin
                if (!(i_hok && i_entry.in_use)) begin
                    o_res.status = STAT_NOT_HANDLE;
                end else begin
                    unique case (i_func)
                        FN_FREE: begin
                            o_act.wr       = 1'b1;
                            o_act.push     = 1'b1;
                            o_entry.in_use = 1'b0;
                            o_entry.lock   = '0;
                            o_entry.word   = i_link;
                        end
                        FN_GET: begin
                            o_res.size_out  = i_entry.word;
                            o_res.is_locked = (i_entry.lock != '0);
                        end
                        FN_SET: begin
                            if (i_entry.lock != '0) begin
                                o_res.status = STAT_LOCKED;
                            end else begin
                                o_act.wr     = 1'b1;
                                o_entry.word = i_size;
                            end
                            o_res.is_locked = (i_entry.lock != '0);
                        end
                        FN_LOCK: begin
                            if (i_entry.word == '0) begin
                                o_res.status = STAT_ZERO_SIZE;
                            end else if (i_entry.lock == LOCK_MAX) begin
                                o_res.status = STAT_LOCK_OVF;
                            end else begin
                                o_act.wr     = 1'b1;
                                o_entry.lock = i_entry.lock + 1'b1;
                            end
                            o_res.is_locked = (o_entry.lock != '0);
                        end
                        FN_UNLOCK: begin
                            if (i_entry.word == '0) begin
                                o_res.status = STAT_ZERO_SIZE;
                            end else if (i_entry.lock == '0) begin
                                o_res.status = STAT_NOT_LOCKED;
                            end else begin
                                o_act.wr     = 1'b1;
                                o_entry.lock = i_entry.lock - 1'b1;
                            end
                            o_res.is_locked = (o_entry.lock != '0);
                        end
                        default: begin
                            o_res.is_locked = (i_entry.lock != '0);
                        end
                    endcase
                end
            end
        endcase
    end

endmodule

[rtl/handle_slot_table.sv]
// ----------------------------------------------------------------------------
// handle_slot_table
// table of handle slots with a last-in first-out free list
// ----------------------------------------------------------------------------
// In each operation the transfer cycle reads the addressed slot entry (for
// alloc, the free list head or the next never-used slot) from the slot memory,
// which has one registered read port and one write port, and the execute state
// then modifies the entry, writes it back and loads the result register. The
// modify step waits while an earlier result is still held in the output
// register. A new operation is taken only once the previous result sits in the
// output register, so operations do not overlap. No clearing pass is needed
// after reset: slots above the used count are never read as live entries.
// Handles are NOT(slot | 0x80000000) with slots numbered from 1.
module handle_slot_table
    import hst_pkg::*;
#(
    parameter int SLOTS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [TDATA_W-1:0] i_s_tdata,   // func[2:0], handle[34:3], size[66:35]
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata    // status[2:0], handle_out[33:3],
                                            // size_out[65:34], is_locked[66]
);

    localparam int CW = $clog2(SLOTS + 1);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic              r_state, n_state;
    logic [CW-1:0]     r_used;
    logic [CW-1:0]     r_head;
    logic              r_out_valid;

    logic [FUNC_W-1:0] r_func;
    logic [WORD_W-1:0] r_size;
    logic [CW-1:0]     r_slot;
    logic              r_hok;
    logic              r_full;
    logic              r_from_list;
    logic [AW-1:0]     r_addr;
    t_res              r_res;
    logic [HOUT_W-1:0] r_hout;

    logic [FUNC_W-1:0] in_func;
    logic [WORD_W-1:0] in_handle;
    logic [WORD_W-1:0] in_size;
    logic [WORD_W-1:0] in_slot32;
    logic [CW-1:0]     in_slot;
    logic              in_hok;
    logic              fh_ok;
    logic              a_full;
    logic [CW-1:0]     a_slot;
    logic [CW-1:0]     sel_slot;
    logic [CW-1:0]     sel_idx;
    logic              rd_ok;
    logic [AW-1:0]     acc_addr;
    logic [AW-1:0]     rd_addr;
    logic              accept;
    logic              done;

    t_entry            rd_entry;
    t_entry            wr_entry;
    t_act              act;
    t_res              res;
    logic [WORD_W-1:0] link;
    logic [WORD_W-1:0] enc;

    assign in_func   = i_s_tdata[2:0];
    assign in_handle = i_s_tdata[34:3];
    assign in_size   = i_s_tdata[66:35];

    // decode handle to slot number and check range against the used count
    assign in_slot32 = ~(in_handle | HANDLE_TAG);
    assign in_slot   = in_slot32[CW-1:0];
    assign in_hok    = ((in_slot32 >> CW) == '0) && (in_slot != '0) && (in_slot <= r_used);

    assign fh_ok    = (r_head != '0) && (r_head <= r_used);
    assign a_full   = !fh_ok && (r_used >= CW'(SLOTS));
    assign a_slot   = fh_ok ? r_head : r_used + 1'b1;
    assign sel_slot = (in_func == FN_ALLOC) ? a_slot : in_slot;
    assign sel_idx  = sel_slot - 1'b1;
    assign rd_ok    = (in_func == FN_ALLOC) ? !a_full : in_hok;
    assign acc_addr = rd_ok ? sel_idx[AW-1:0] : '0;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign done       = (r_state == S_EXEC) && (!r_out_valid || i_m_tready);
    assign rd_addr    = (r_state == S_IDLE) ? acc_addr : r_addr;

    hst_mem #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_entry),
        .i_wr_en   (done && act.wr),
        .i_wr_addr (r_addr),
        .i_wr_data (wr_entry)
    );

    assign link = {{(WORD_W-CW){1'b0}}, r_head};

    hst_exec u_exec (
        .i_func      (r_func),
        .i_size      (r_size),
        .i_hok       (r_hok),
        .i_full      (r_full),
        .i_from_list (r_from_list),
        .i_link      (link),
        .i_entry     (rd_entry),
        .o_entry     (wr_entry),
        .o_act       (act),
        .o_res       (res)
    );

    assign enc = ~({{(WORD_W-CW){1'b0}}, r_slot} | HANDLE_TAG);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (done) begin
                r_out_valid <= 1'b1;
                if (act.grow) begin
                    r_used <= r_used + 1'b1;
                end
                if (act.pop) begin
                    r_head <= rd_entry.word[CW-1:0];
                end else if (act.push) begin
                    r_head <= r_slot;
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func      <= in_func;
            r_size      <= in_size;
            r_slot      <= sel_slot;
            r_hok       <= in_hok;
            r_full      <= a_full;
            r_from_list <= fh_ok;
            r_addr      <= acc_addr;
        end
        if (done) begin
            r_res  <= res;
            r_hout <= (act.grow || act.pop) ? enc[HOUT_W-1:0] : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_res.is_locked, r_res.size_out, r_hout, r_res.status};

endmodule

[rtl/hst_checker.sv]
// ----------------------------------------------------------------------------
// hst_checker
// port-level checks of the handle slot table, bound to the top level
// ----------------------------------------------------------------------------
`include "handle_slot_table_macros.svh"

module hst_checker
    import hst_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_s_tvalid,
    input logic               o_s_tready,
    input logic               o_m_tvalid,
    input logic               i_m_tready,
    input logic [TDATA_W-1:0] o_m_tdata
);

    // a stalled result keeps its value
    `HST_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, $stable(o_m_tdata) && o_m_tvalid)

    // one operation at a time: no transfer in the cycle after a transfer
    `HST_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

    // the unused status code never appears
    `HST_ASSERT_IMP(a_status_range, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[2:0] != STAT_UNUSED)

    // a failed operation never hands out a handle
    `HST_ASSERT_IMP(a_fail_no_handle, i_clk, i_rst_n, o_m_tvalid && (o_m_tdata[2:0] != STAT_OK), o_m_tdata[33:3] == '0)

endmodule

bind handle_slot_table hst_checker u_hst_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
